// File: hdl/fcpt_pkg.sv
package fcpt_pkg;

	localparam int KEY_W  = 48;
	localparam int TIME_W = 32;
	localparam int ERR_W  = 12;
	localparam int ECNT_W = 16;
	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CL_ENTER_HIT,
		CL_INSERT,
		CL_FULL,
		CL_EXIT_HIT,
		CL_EXIT_MISS
	} class_t;

	typedef enum logic {
		BK_READ,
		BK_WRITE
	} back_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] calls;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] min_t;
		logic [TIME_W-1:0] max_t;
		logic [ERR_W-1:0]  err_start;
		logic [ECNT_W-1:0] err_cnt;
		logic [ERR_W-1:0]  last_err;
	} entry_t;

	typedef struct packed {
		logic              push;
		logic              full;
	} q_ctrl_t;

endpackage

// File: hdl/function_call_profile_table.sv
// Channel   Handshake      Payload
// command   start / busy   req_type, fn_address, timestamp, err_code
// result    done strobe    status, slot, calls, elapsed, min_time, max_time,
//                          errors, last_error, error_now
// The back end takes an item in two states: a read state for the entry
// memory read, then a write step for the update write and the result
// register; it pops no new item before that write step. done is registered
// in the write step of its item, later when earlier items wait in the queue.
// busy rises while the two-deep queue is full. Reset
// clears valid bits, fill count and queue; entry data is written on insert.
// done lasts one cycle and cannot be held off.
module function_call_profile_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [fcpt_pkg::KEY_W-1:0]    fn_address,
	input  logic [fcpt_pkg::TIME_W-1:0]   timestamp,
	input  logic [fcpt_pkg::ERR_W-1:0]    err_code,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [fcpt_pkg::SLOT_W-1:0]   slot,
	output logic [fcpt_pkg::TIME_W-1:0]   calls,
	output logic [fcpt_pkg::TIME_W-1:0]   elapsed,
	output logic [fcpt_pkg::TIME_W-1:0]   min_time,
	output logic [fcpt_pkg::TIME_W-1:0]   max_time,
	output logic [fcpt_pkg::ECNT_W-1:0]   errors,
	output logic [fcpt_pkg::ERR_W-1:0]    last_error,
	output logic                          error_now
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $bits(fcpt_pkg::class_t);
	localparam int QW = CW + IW + fcpt_pkg::TIME_W + fcpt_pkg::ERR_W;

	fcpt_pkg::q_ctrl_t       qc;
	fcpt_pkg::class_t        f_cls;
	logic [IW-1:0]           f_idx;
	logic [QW-1:0]           q_rdata;
	logic                    q_empty;
	logic                    q_pop;

	assign busy    = qc.full;
	assign qc.push = start && !qc.full;

	fcpt_front #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(qc.push), .fn_address(fn_address),
		.req_type(req_type), .cls(f_cls), .idx(f_idx)
	);

	fcpt_fifo #(.W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(qc.push),
		.wdata({f_cls, f_idx, timestamp, err_code}),
		.pop(q_pop), .rdata(q_rdata), .empty(q_empty), .full(qc.full)
	);

	fcpt_back #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_pop(q_pop),
		.q_cls(fcpt_pkg::class_t'(q_rdata[QW-1 -: CW])),
		.q_idx(q_rdata[QW-CW-1 -: IW]),
		.q_ts(q_rdata[fcpt_pkg::ERR_W +: fcpt_pkg::TIME_W]),
		.q_err(q_rdata[fcpt_pkg::ERR_W-1:0]),
		.done(done), .status(status), .slot(slot), .calls(calls), .elapsed(elapsed),
		.min_time(min_time), .max_time(max_time), .errors(errors),
		.last_error(last_error), .error_now(error_now)
	);

endmodule

// File: hdl/fcpt_front.sv
module fcpt_front #(
	parameter int ENTRIES = 64,
	parameter int IW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [fcpt_pkg::KEY_W-1:0] fn_address,
	input  logic                       req_type,
	output fcpt_pkg::class_t           cls,
	output logic [IW-1:0]              idx
);

	localparam int FW = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0]              valid_q;
	logic [fcpt_pkg::KEY_W-1:0]      key_q [ENTRIES];
	logic [FW-1:0]                   fill_q;
	logic                            hit;
	logic [IW-1:0]                   hit_idx;
	logic                            room;

	// lowest matching valid entry wins
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == fn_address) begin
				hit = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	assign room = fill_q < FW'(ENTRIES);

	always_comb begin
		idx = hit_idx;
		if (req_type) begin
			cls = hit ? fcpt_pkg::CL_EXIT_HIT : fcpt_pkg::CL_EXIT_MISS;
		end else if (hit) begin
			cls = fcpt_pkg::CL_ENTER_HIT;
		end else if (room) begin
			cls = fcpt_pkg::CL_INSERT;
			idx = fill_q[IW-1:0];
		end else begin
			cls = fcpt_pkg::CL_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (accept && cls == fcpt_pkg::CL_INSERT) begin
			valid_q[fill_q[IW-1:0]] <= 1'b1;
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cls == fcpt_pkg::CL_INSERT) begin
			key_q[fill_q[IW-1:0]] <= fn_address;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(ENTRIES)) else $error("fill count past table end");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cls == fcpt_pkg::CL_INSERT) |=> fill_q == $past(fill_q) + FW'(1))
		else $error("insert did not advance fill count");

endmodule

// File: hdl/fcpt_fifo.sv
module fcpt_fifo #(
	parameter int W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wdata,
	input  logic             pop,
	output logic [W-1:0]     rdata,
	output logic             empty,
	output logic             full
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");

endmodule

// File: hdl/fcpt_back.sv
module fcpt_back #(
	parameter int ENTRIES = 64,
	parameter int IW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  fcpt_pkg::class_t              q_cls,
	input  logic [IW-1:0]                 q_idx,
	input  logic [fcpt_pkg::TIME_W-1:0]   q_ts,
	input  logic [fcpt_pkg::ERR_W-1:0]    q_err,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [fcpt_pkg::SLOT_W-1:0]   slot,
	output logic [fcpt_pkg::TIME_W-1:0]   calls,
	output logic [fcpt_pkg::TIME_W-1:0]   elapsed,
	output logic [fcpt_pkg::TIME_W-1:0]   min_time,
	output logic [fcpt_pkg::TIME_W-1:0]   max_time,
	output logic [fcpt_pkg::ECNT_W-1:0]   errors,
	output logic [fcpt_pkg::ERR_W-1:0]    last_error,
	output logic                          error_now
);

	fcpt_pkg::back_state_t           state_q, state_d;
	fcpt_pkg::entry_t                mem [ENTRIES];
	fcpt_pkg::entry_t                rd_q;
	fcpt_pkg::entry_t                nx;
	fcpt_pkg::class_t                cls_q;
	logic [IW-1:0]                   idx_q;
	logic [fcpt_pkg::TIME_W-1:0]     ts_q;
	logic [fcpt_pkg::ERR_W-1:0]      err_q;
	logic                            we;
	logic [fcpt_pkg::TIME_W-1:0]     el;
	logic                            chg;
	logic                            emit_entry;
	logic [1:0]                      st_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fcpt_pkg::BK_READ:  if (!q_empty) state_d = fcpt_pkg::BK_WRITE;
			fcpt_pkg::BK_WRITE: state_d = fcpt_pkg::BK_READ;
			default:            state_d = fcpt_pkg::BK_READ;
		endcase
	end

	always_comb begin
		q_pop = state_q == fcpt_pkg::BK_READ && !q_empty;
		we = state_q == fcpt_pkg::BK_WRITE && (cls_q inside {fcpt_pkg::CL_ENTER_HIT,
			fcpt_pkg::CL_INSERT, fcpt_pkg::CL_EXIT_HIT});
	end

	assign el  = ts_q - rd_q.start;
	assign chg = err_q != rd_q.err_start;

	// updated entry image, also what the result shows
	always_comb begin
		nx = rd_q;
		emit_entry = 1'b1;
		st_d = fcpt_pkg::ST_HIT;
		case (cls_q)
			fcpt_pkg::CL_ENTER_HIT: begin
				if (rd_q.calls != '1) nx.calls = rd_q.calls + 1'b1;
				nx.start = ts_q;
				nx.err_start = err_q;
			end
			fcpt_pkg::CL_INSERT: begin
				st_d = fcpt_pkg::ST_INSERTED;
				nx.calls = 32'd1;
				nx.start = ts_q;
				nx.min_t = '1;
				nx.max_t = '0;
				nx.err_start = err_q;
				nx.err_cnt = '0;
				nx.last_err = '0;
			end
			fcpt_pkg::CL_EXIT_HIT: begin
				if (el < rd_q.min_t) nx.min_t = el;
				if (el > rd_q.max_t) nx.max_t = el;
				if (chg) begin
					if (rd_q.err_cnt != '1) nx.err_cnt = rd_q.err_cnt + 1'b1;
					nx.last_err = err_q;
				end
			end
			fcpt_pkg::CL_FULL: begin
				st_d = fcpt_pkg::ST_FULL;
				emit_entry = 1'b0;
			end
			default: begin
				st_d = fcpt_pkg::ST_NOTFOUND;
				emit_entry = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcpt_pkg::BK_READ;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= state_q == fcpt_pkg::BK_WRITE;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_q  <= mem[q_idx];
			cls_q <= q_cls;
			idx_q <= q_idx;
			ts_q  <= q_ts;
			err_q <= q_err;
		end
		if (we) mem[idx_q] <= nx;
	end

	always_ff @(posedge clk) begin
		if (state_q == fcpt_pkg::BK_WRITE) begin
			status     <= st_d;
			slot       <= emit_entry ? fcpt_pkg::SLOT_W'(idx_q) : '0;
			calls      <= emit_entry ? nx.calls : '0;
			elapsed    <= (cls_q == fcpt_pkg::CL_EXIT_HIT) ? el : '0;
			min_time   <= emit_entry ? nx.min_t : '0;
			max_time   <= emit_entry ? nx.max_t : '0;
			errors     <= emit_entry ? nx.err_cnt : '0;
			last_error <= emit_entry ? nx.last_err : '0;
			error_now  <= cls_q == fcpt_pkg::CL_EXIT_HIT && chg;
		end
	end

	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == fcpt_pkg::BK_WRITE)) else $error("stray result strobe");
	a_pop_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == fcpt_pkg::BK_WRITE) else $error("pop without write step");

endmodule
